>>> design/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Types and constants shared by the piecewise linear scale lookup modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

   localparam int DATA_W              = 16;
   localparam int MAX_BREAKPOINTS_DEF = 8;
   localparam int STEP_W              = 4;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);
   localparam logic [DATA_W-1:0] SCALE_ONE = 16'd4096;

   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_QUERY  = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]               req_type;
      logic signed [DATA_W-1:0] query_pos;
      logic signed [DATA_W-1:0] entry_pos;
      logic [DATA_W-1:0]        entry_scale;
   } pls_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] scale_out;
      logic              status;
   } pls_rsp_type;

   typedef struct packed {
      logic              load;
      logic [DATA_W-1:0] multiplicand;
      logic [DATA_W-1:0] multiplier;
      logic [DATA_W-1:0] divisor;
   } pls_arith_cmd_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] quotient;
   } pls_arith_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CALC
   } pls_state_type;

   typedef enum logic [1:0] {
      AR_IDLE,
      AR_MUL,
      AR_DIV
   } pls_arith_state_type;

endpackage

`default_nettype wire

>>> design/piecewise_linear_scale_lookup.sv
// Append, clear and query on an empty table: result strobe in the cycle after accept.
// Query: the table is scanned one entry a cycle through the registered read port;
// a result without interpolation follows in the cycle after the deciding entry.
// Interpolation between the bracketing entries adds a bit-serial multiply and a
// bit-serial divide. Reset empties the table; entries are undefined until written.
// Results cannot be stalled; busy stays high while a query is in progress.
// ----------------------------------------------------------------------------
// piecewise_linear_scale_lookup
// Breakpoint table with scale lookup by linear interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_scale_lookup #(
   parameter int MAX_BREAKPOINTS = pls_pkg::MAX_BREAKPOINTS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire pls_pkg::pls_req_type req_item,
   output logic                      rsp_valid,
   output pls_pkg::pls_rsp_type      rsp_item
);
   import pls_pkg::*;

   localparam int IDX_W = $clog2(MAX_BREAKPOINTS);
   localparam int CNT_W = $clog2(MAX_BREAKPOINTS + 1);

   pls_state_type            state_ff, state_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [DATA_W-1:0] q_ff, q_in;
   logic signed [DATA_W-1:0] prev_pos_ff, prev_pos_in;
   logic [DATA_W-1:0]        prev_scale_ff, prev_scale_in;
   logic                     neg_ff, neg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        rsp_scale_ff, rsp_scale_in;
   logic                     rsp_status_ff, rsp_status_in;

   logic                     tbl_wr;
   logic                     tbl_clear;
   logic [IDX_W-1:0]         rd_addr;
   logic signed [DATA_W-1:0] rd_pos;
   logic [DATA_W-1:0]        rd_scale;
   logic [CNT_W-1:0]         tbl_count;
   logic                     tbl_full;
   logic [DATA_W:0]          ds;
   logic                     last_entry;
   pls_arith_cmd_type        arith_cmd;
   pls_arith_rsp_type        arith_rsp;

   pls_table #(
      .MAX_BREAKPOINTS (MAX_BREAKPOINTS),
      .IDX_W           (IDX_W),
      .CNT_W           (CNT_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr),
      .wr_pos   (req_item.entry_pos),
      .wr_scale (req_item.entry_scale),
      .clear    (tbl_clear),
      .rd_addr  (rd_addr),
      .rd_pos   (rd_pos),
      .rd_scale (rd_scale),
      .count    (tbl_count),
      .full     (tbl_full)
   );

   pls_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (arith_cmd),
      .rsp   (arith_rsp)
   );

   assign ds         = {1'b0, rd_scale} - {1'b0, prev_scale_ff};
   assign last_entry = ((CNT_W'(idx_ff) + 1'b1) == tbl_count);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      q_ff          <= q_in;
      prev_pos_ff   <= prev_pos_in;
      prev_scale_ff <= prev_scale_in;
      neg_ff        <= neg_in;
      rsp_scale_ff  <= rsp_scale_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      q_in          = q_ff;
      prev_pos_in   = prev_pos_ff;
      prev_scale_in = prev_scale_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = 1'b0;
      rsp_scale_in  = rsp_scale_ff;
      rsp_status_in = rsp_status_ff;
      tbl_wr        = 1'b0;
      tbl_clear     = 1'b0;
      rd_addr       = '0;
      arith_cmd     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_scale_in  = '0;
               rsp_status_in = 1'b0;
               case (req_item.req_type)
                  REQ_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (tbl_full) begin
                        rsp_status_in = 1'b1;
                     end else begin
                        tbl_wr = 1'b1;
                     end
                  end
                  REQ_QUERY: begin
                     if (tbl_count == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_scale_in = SCALE_ONE;
                     end else begin
                        q_in     = req_item.query_pos;
                        idx_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  REQ_CLEAR: begin
                     rsp_valid_in = 1'b1;
                     tbl_clear    = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_addr = idx_ff + 1'b1;
            if (q_ff < rd_pos) begin
               if (idx_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_scale_in = rd_scale;
                  state_in     = ST_IDLE;
               end else begin
                  arith_cmd.load         = 1'b1;
                  arith_cmd.multiplicand = ds[DATA_W] ? DATA_W'(-ds) : ds[DATA_W-1:0];
                  arith_cmd.multiplier   = DATA_W'(q_ff - prev_pos_ff);
                  arith_cmd.divisor      = DATA_W'(rd_pos - prev_pos_ff);
                  neg_in                 = ds[DATA_W];
                  state_in               = ST_CALC;
               end
            end else begin
               prev_pos_in   = rd_pos;
               prev_scale_in = rd_scale;
               if (last_entry) begin
                  rsp_valid_in = 1'b1;
                  rsp_scale_in = rd_scale;
                  state_in     = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_CALC: begin
            if (arith_rsp.done) begin
               rsp_valid_in = 1'b1;
               rsp_scale_in = neg_ff ? (prev_scale_ff - arith_rsp.quotient)
                                     : (prev_scale_ff + arith_rsp.quotient);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_item.scale_out = rsp_scale_ff;
   assign rsp_item.status    = rsp_status_ff;

`ifndef SYNTHESIS
   // A dropped append never carries a scale.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status |-> rsp_item.scale_out == '0)
      else $error("dropped append returned a nonzero scale");

   // A query on an empty table answers 1.0 in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.req_type == REQ_QUERY && tbl_count == '0
      |=> rsp_valid && rsp_item.scale_out == SCALE_ONE)
      else $error("empty table query did not return unity scale");

   // The arithmetic unit only finishes while a query waits on it.
   assert property (@(posedge clock) disable iff (reset)
      arith_rsp.done |-> state_ff == ST_CALC)
      else $error("arithmetic result arrived outside of interpolation");

   // The fill count never passes the table depth.
   assert property (@(posedge clock) disable iff (reset)
      tbl_count <= CNT_W'(MAX_BREAKPOINTS))
      else $error("breakpoint count exceeds table depth");
`endif

endmodule

`default_nettype wire

>>> design/pls_table.sv
// ----------------------------------------------------------------------------
// pls_table
// Breakpoint store with one write port, one registered read port and a fill
// count.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_table #(
   parameter int MAX_BREAKPOINTS = pls_pkg::MAX_BREAKPOINTS_DEF,
   parameter int IDX_W           = $clog2(MAX_BREAKPOINTS),
   parameter int CNT_W           = $clog2(MAX_BREAKPOINTS + 1)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             wr_en,
   input  wire logic signed [pls_pkg::DATA_W-1:0] wr_pos,
   input  wire logic [pls_pkg::DATA_W-1:0]       wr_scale,
   input  wire logic                             clear,
   input  wire logic [IDX_W-1:0]                 rd_addr,
   output logic signed [pls_pkg::DATA_W-1:0]     rd_pos,
   output logic [pls_pkg::DATA_W-1:0]            rd_scale,
   output logic [CNT_W-1:0]                      count,
   output logic                                  full
);
   import pls_pkg::*;

   logic signed [DATA_W-1:0] pos_mem [MAX_BREAKPOINTS];
   logic [DATA_W-1:0]        scale_mem [MAX_BREAKPOINTS];
   logic signed [DATA_W-1:0] rd_pos_ff;
   logic [DATA_W-1:0]        rd_scale_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;

   assign full = (count_ff == CNT_W'(MAX_BREAKPOINTS));

   always_comb begin
      count_in = count_ff;
      if (clear) begin
         count_in = '0;
      end else if (wr_en && !full) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && !full) begin
         pos_mem[count_ff[IDX_W-1:0]]   <= wr_pos;
         scale_mem[count_ff[IDX_W-1:0]] <= wr_scale;
      end
      rd_pos_ff   <= pos_mem[rd_addr];
      rd_scale_ff <= scale_mem[rd_addr];
   end

   assign rd_pos   = rd_pos_ff;
   assign rd_scale = rd_scale_ff;
   assign count    = count_ff;

endmodule

`default_nettype wire

>>> design/pls_arith.sv
// ----------------------------------------------------------------------------
// pls_arith
// Bit-serial unsigned multiply followed by a bit-serial restoring divide,
// sharing one shift register pair.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_arith (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire pls_pkg::pls_arith_cmd_type cmd,
   output pls_pkg::pls_arith_rsp_type      rsp
);
   import pls_pkg::*;

   pls_arith_state_type state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [DATA_W-1:0]   hi_ff, hi_in;
   logic [DATA_W-1:0]   lo_ff, lo_in;
   logic [DATA_W-1:0]   mcand_ff, mcand_in;
   logic [DATA_W-1:0]   divisor_ff, divisor_in;
   logic                done_ff, done_in;
   logic [DATA_W:0]     mul_sum;
   logic [DATA_W:0]     trial;
   logic [DATA_W:0]     diff;
   logic                fits;

   assign mul_sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
   assign trial   = {hi_ff, lo_ff[DATA_W-1]};
   assign diff    = trial - {1'b0, divisor_ff};
   assign fits    = (trial >= {1'b0, divisor_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AR_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
      mcand_ff   <= mcand_in;
      divisor_ff <= divisor_in;
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      hi_in      = hi_ff;
      lo_in      = lo_ff;
      mcand_in   = mcand_ff;
      divisor_in = divisor_ff;
      done_in    = 1'b0;
      unique case (state_ff)
         AR_IDLE: begin
            if (cmd.load) begin
               hi_in      = '0;
               lo_in      = cmd.multiplier;
               mcand_in   = cmd.multiplicand;
               divisor_in = cmd.divisor;
               step_in    = '0;
               state_in   = AR_MUL;
            end
         end
         AR_MUL: begin
            hi_in   = mul_sum[DATA_W:1];
            lo_in   = {mul_sum[0], lo_ff[DATA_W-1:1]};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               state_in = AR_DIV;
            end
         end
         AR_DIV: begin
            hi_in   = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            lo_in   = {lo_ff[DATA_W-2:0], fits};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               done_in  = 1'b1;
               state_in = AR_IDLE;
            end
         end
         default: begin
            state_in = AR_IDLE;
         end
      endcase
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = lo_ff;

endmodule

`default_nettype wire
